@@ hdl/presence_hysteresis_fsm_macros.svh @@
// assertion macros for the presence hysteresis block
// used by the top level only, expects clk and arst_n in scope

`ifndef PRESENCE_HYSTERESIS_FSM_MACROS_SVH
`define PRESENCE_HYSTERESIS_FSM_MACROS_SVH

// same-cycle implication, disabled during reset
`define PHF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PHF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/phf_pkg.sv @@
// shared types, codes and reset values for the presence hysteresis block
// no dependencies
`timescale 1ns / 1ps

package phf_pkg;

	localparam int unsigned LIMIT_W = 24;
	localparam int unsigned SINCE_W = 25;
	localparam int unsigned WIDE_W  = 32;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned DT_W    = 16;
	localparam int unsigned BOX_W   = 12;
	localparam int unsigned REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_HOLD   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAYBE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEUR   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_AWAY   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ENGAGE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RETURN = 3'd6;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_FACE      = 3'd1,
		OP_HEUR_HIGH = 3'd2,
		OP_HEUR_LOW  = 3'd3,
		OP_LINK_DOWN = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_ACQUIRED   = 3'd1,
		EV_CONFIRMED  = 3'd2,
		EV_RETURNED   = 3'd3,
		EV_LOST_SHORT = 3'd4,
		EV_ENGAGED    = 3'd5,
		EV_AWAY       = 3'd6,
		EV_SETTLED    = 3'd7
	} event_t;

	// presence states, one-hot
	typedef enum logic [6:0] {
		ST_NONE    = 7'b0000001,
		ST_MAYBE   = 7'b0000010,
		ST_PRESENT = 7'b0000100,
		ST_ENGAGED = 7'b0001000,
		ST_LEFT    = 7'b0010000,
		ST_AWAY    = 7'b0100000,
		ST_SETTLED = 7'b1000000
	} state_t;

	// external state codes
	localparam logic [2:0] CODE_NONE    = 3'd0;
	localparam logic [2:0] CODE_MAYBE   = 3'd1;
	localparam logic [2:0] CODE_PRESENT = 3'd2;
	localparam logic [2:0] CODE_ENGAGED = 3'd3;
	localparam logic [2:0] CODE_LEFT    = 3'd4;
	localparam logic [2:0] CODE_AWAY    = 3'd5;
	localparam logic [2:0] CODE_SETTLED = 3'd6;

	typedef struct packed {
		logic [LIMIT_W-1:0] hold_limit_ms;
		logic [LIMIT_W-1:0] maybe_limit_ms;
		logic [LIMIT_W-1:0] heuristic_limit_ms;
		logic [LIMIT_W-1:0] left_limit_ms;
		logic [LIMIT_W-1:0] away_limit_ms;
		logic [LIMIT_W-1:0] engage_limit_ms;
		logic [LIMIT_W-1:0] return_limit_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		hold_limit_ms:      24'd5000,
		maybe_limit_ms:     24'd5000,
		heuristic_limit_ms: 24'd10000,
		left_limit_ms:      24'd30000,
		away_limit_ms:      24'd120000,
		engage_limit_ms:    24'd180000,
		return_limit_ms:    24'd60000
	};

	typedef struct packed {
		logic [2:0]       op;
		logic [DT_W-1:0]  dt_ms;
		logic [BOX_W-1:0] face_width;
		logic [BOX_W-1:0] face_height;
	} item_t;

	typedef struct packed {
		state_t             presence;
		logic               face_seen;
		logic               heuristic_seen;
		logic               confidence;
		logic [LIMIT_W-1:0] hold_timer;
		logic [LIMIT_W-1:0] maybe_timer;
		logic [LIMIT_W-1:0] heuristic_timer;
		logic [LIMIT_W-1:0] engage_timer;
		logic [SINCE_W-1:0] since_left_timer;
		logic [WIDE_W-1:0]  session_timer;
		logic [WIDE_W-1:0]  absence_timer;
		logic [CNT_W-1:0]   confirm_cnt;
		logic [CNT_W-1:0]   return_cnt;
		logic [CNT_W-1:0]   away_cnt;
	} fsm_state_t;

	localparam fsm_state_t STATE_RESET = '{
		presence:         ST_NONE,
		face_seen:        1'b0,
		heuristic_seen:   1'b0,
		confidence:       1'b0,
		hold_timer:       '0,
		maybe_timer:      '0,
		heuristic_timer:  '0,
		engage_timer:     '0,
		since_left_timer: '0,
		session_timer:    '0,
		absence_timer:    '0,
		confirm_cnt:      '0,
		return_cnt:       '0,
		away_cnt:         '0
	};

	typedef struct packed {
		logic [2:0]        event_kind;
		logic [2:0]        old_state;
		logic [2:0]        new_state;
		logic              face_flag;
		logic [2:0]        current_state;
		logic              face_confidence;
		logic [CNT_W-1:0]  confirmed_total;
		logic [CNT_W-1:0]  returned_total;
		logic [CNT_W-1:0]  away_total;
		logic [WIDE_W-1:0] session_time_ms;
		logic [WIDE_W-1:0] absence_time_ms;
	} result_t;

	function automatic logic [2:0] state_code(input state_t s);
		logic [2:0] c;
		case (s)
			ST_NONE:    c = CODE_NONE;
			ST_MAYBE:   c = CODE_MAYBE;
			ST_PRESENT: c = CODE_PRESENT;
			ST_ENGAGED: c = CODE_ENGAGED;
			ST_LEFT:    c = CODE_LEFT;
			ST_AWAY:    c = CODE_AWAY;
			ST_SETTLED: c = CODE_SETTLED;
			default:    c = CODE_NONE;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/phf_item_if.sv @@
// request channel carrying one sensor or tick item
// depends on phf_pkg for field widths
`timescale 1ns / 1ps

interface phf_item_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    op;
	logic [phf_pkg::DT_W-1:0]      dt_ms;
	logic [phf_pkg::BOX_W-1:0]     face_width;
	logic [phf_pkg::BOX_W-1:0]     face_height;

	modport source (output valid, op, dt_ms, face_width, face_height, input ready);
	modport sink   (input valid, op, dt_ms, face_width, face_height, output ready);
endinterface

@@ hdl/phf_result_if.sv @@
// channel carrying one result of the presence machine
// depends on phf_pkg for field widths
`timescale 1ns / 1ps

interface phf_result_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_kind;
	logic [2:0]                    old_state;
	logic [2:0]                    new_state;
	logic                          face_flag;
	logic [2:0]                    current_state;
	logic                          face_confidence;
	logic [phf_pkg::CNT_W-1:0]     confirmed_total;
	logic [phf_pkg::CNT_W-1:0]     returned_total;
	logic [phf_pkg::CNT_W-1:0]     away_total;
	logic [phf_pkg::WIDE_W-1:0]    session_time_ms;
	logic [phf_pkg::WIDE_W-1:0]    absence_time_ms;

	modport source (output valid, event_kind, old_state, new_state, face_flag, current_state,
		face_confidence, confirmed_total, returned_total, away_total,
		session_time_ms, absence_time_ms, input ready);
	modport sink   (input valid, event_kind, old_state, new_state, face_flag, current_state,
		face_confidence, confirmed_total, returned_total, away_total,
		session_time_ms, absence_time_ms, output ready);
endinterface

@@ hdl/phf_cfg_regs.sv @@
// limit register file, written through a plain indexed write port
// depends on phf_pkg
`timescale 1ns / 1ps

module phf_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              write_en,
	input  logic [phf_pkg::REG_IDX_W-1:0]     reg_index,
	input  logic [phf_pkg::LIMIT_W-1:0]       write_data,
	output phf_pkg::cfg_t                     cfg
);

	phf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= phf_pkg::CFG_RESET;
		end else if (write_en) begin
			case (reg_index)
				phf_pkg::REG_HOLD:   cfg_q.hold_limit_ms      <= write_data;
				phf_pkg::REG_MAYBE:  cfg_q.maybe_limit_ms     <= write_data;
				phf_pkg::REG_HEUR:   cfg_q.heuristic_limit_ms <= write_data;
				phf_pkg::REG_LEFT:   cfg_q.left_limit_ms      <= write_data;
				phf_pkg::REG_AWAY:   cfg_q.away_limit_ms      <= write_data;
				phf_pkg::REG_ENGAGE: cfg_q.engage_limit_ms    <= write_data;
				phf_pkg::REG_RETURN: cfg_q.return_limit_ms    <= write_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/phf_step.sv @@
// next-state and result logic for one item of the presence machine
// depends on phf_pkg
`timescale 1ns / 1ps

module phf_step (
	input  phf_pkg::fsm_state_t cur,
	input  phf_pkg::item_t      item,
	input  phf_pkg::cfg_t       cfg,
	output phf_pkg::fsm_state_t nxt,
	output phf_pkg::result_t    res
);

	localparam logic [phf_pkg::LIMIT_W-1:0] MAX24 = '1;
	localparam logic [phf_pkg::SINCE_W-1:0] MAX25 = '1;

	logic                           sig;
	logic                           fv;
	logic                           flag;
	logic                           face_ok;
	phf_pkg::event_t                ev;
	logic [phf_pkg::LIMIT_W:0]      hold_sum, maybe_sum, heur_sum, engage_sum;
	logic [phf_pkg::SINCE_W:0]      since_sum;
	logic [phf_pkg::LIMIT_W-1:0]    hold_sat, maybe_sat, heur_sat, engage_sat;
	logic [phf_pkg::SINCE_W-1:0]    since_sat;
	logic [phf_pkg::SINCE_W-1:0]    settle_limit;
	logic [phf_pkg::WIDE_W-1:0]     dt_wide;

	// saturating timer updates
	always_comb begin
		hold_sum   = {1'b0, cur.hold_timer}      + 25'(item.dt_ms);
		maybe_sum  = {1'b0, cur.maybe_timer}     + 25'(item.dt_ms);
		heur_sum   = {1'b0, cur.heuristic_timer} + 25'(item.dt_ms);
		engage_sum = {1'b0, cur.engage_timer}    + 25'(item.dt_ms);
		since_sum  = {1'b0, cur.since_left_timer} + 26'(item.dt_ms);
		hold_sat   = hold_sum[phf_pkg::LIMIT_W]   ? MAX24 : hold_sum[phf_pkg::LIMIT_W-1:0];
		maybe_sat  = maybe_sum[phf_pkg::LIMIT_W]  ? MAX24 : maybe_sum[phf_pkg::LIMIT_W-1:0];
		heur_sat   = heur_sum[phf_pkg::LIMIT_W]   ? MAX24 : heur_sum[phf_pkg::LIMIT_W-1:0];
		engage_sat = engage_sum[phf_pkg::LIMIT_W] ? MAX24 : engage_sum[phf_pkg::LIMIT_W-1:0];
		since_sat  = since_sum[phf_pkg::SINCE_W]  ? MAX25 : since_sum[phf_pkg::SINCE_W-1:0];
		settle_limit = 25'(cfg.left_limit_ms) + 25'(cfg.away_limit_ms);
		dt_wide    = 32'(item.dt_ms);
	end

	always_comb begin
		nxt     = cur;
		ev      = phf_pkg::EV_NONE;
		flag    = 1'b0;
		sig     = cur.face_seen | cur.heuristic_seen;
		fv      = cur.face_seen;
		face_ok = (item.face_width != '0) && (item.face_height != '0);

		case (item.op)
			phf_pkg::OP_TICK: begin
				// session and absence bookkeeping on the state before the tick
				if (cur.presence == phf_pkg::ST_PRESENT || cur.presence == phf_pkg::ST_ENGAGED) begin
					nxt.session_timer = cur.session_timer + dt_wide;
					nxt.absence_timer = '0;
				end else if (!sig) begin
					nxt.absence_timer = cur.absence_timer + dt_wide;
				end else begin
					nxt.absence_timer = '0;
				end

				case (cur.presence)
					phf_pkg::ST_NONE: begin
						if (sig) begin
							nxt.presence        = phf_pkg::ST_MAYBE;
							nxt.maybe_timer     = '0;
							nxt.heuristic_timer = '0;
							ev                  = phf_pkg::EV_ACQUIRED;
						end
					end
					phf_pkg::ST_SETTLED: begin
						if (sig) begin
							nxt.presence     = phf_pkg::ST_PRESENT;
							nxt.hold_timer   = '0;
							nxt.engage_timer = '0;
							if (fv) nxt.confidence = 1'b1;
							nxt.return_cnt   = cur.return_cnt + 16'd1;
							ev               = phf_pkg::EV_RETURNED;
							flag             = fv;
						end
					end
					phf_pkg::ST_MAYBE: begin
						if (!sig) begin
							nxt.maybe_timer = maybe_sat;
							// silent fall back to none
							if (maybe_sat >= cfg.maybe_limit_ms) begin
								nxt.presence        = phf_pkg::ST_NONE;
								nxt.maybe_timer     = '0;
								nxt.heuristic_timer = '0;
							end
						end else begin
							nxt.maybe_timer = '0;
							if (fv) begin
								nxt.presence     = phf_pkg::ST_PRESENT;
								nxt.confidence   = 1'b1;
								nxt.engage_timer = '0;
								nxt.hold_timer   = '0;
								nxt.confirm_cnt  = cur.confirm_cnt + 16'd1;
								ev               = phf_pkg::EV_CONFIRMED;
								flag             = 1'b1;
							end else begin
								nxt.heuristic_timer = heur_sat;
								if (heur_sat >= cfg.heuristic_limit_ms) begin
									nxt.presence     = phf_pkg::ST_PRESENT;
									nxt.confidence   = 1'b0;
									nxt.engage_timer = '0;
									nxt.hold_timer   = '0;
									nxt.confirm_cnt  = cur.confirm_cnt + 16'd1;
									ev               = phf_pkg::EV_CONFIRMED;
								end
							end
						end
					end
					phf_pkg::ST_PRESENT: begin
						nxt.engage_timer = engage_sat;
						if (sig) begin
							nxt.hold_timer = '0;
							if (fv) nxt.confidence = 1'b1;
						end else begin
							nxt.hold_timer = hold_sat;
						end
						if (!sig && hold_sat >= cfg.hold_limit_ms) begin
							nxt.presence         = phf_pkg::ST_LEFT;
							nxt.since_left_timer = '0;
							nxt.engage_timer     = '0;
							nxt.hold_timer       = '0;
							ev                   = phf_pkg::EV_LOST_SHORT;
						end else if (engage_sat >= cfg.engage_limit_ms) begin
							nxt.presence = phf_pkg::ST_ENGAGED;
							ev           = phf_pkg::EV_ENGAGED;
						end
					end
					phf_pkg::ST_ENGAGED: begin
						if (sig) begin
							nxt.hold_timer = '0;
							if (fv) nxt.confidence = 1'b1;
						end else begin
							nxt.hold_timer = hold_sat;
							if (hold_sat >= cfg.hold_limit_ms) begin
								nxt.presence         = phf_pkg::ST_LEFT;
								nxt.since_left_timer = '0;
								nxt.hold_timer       = '0;
								ev                   = phf_pkg::EV_LOST_SHORT;
							end
						end
					end
					phf_pkg::ST_LEFT: begin
						nxt.since_left_timer = since_sat;
						if (sig) begin
							nxt.presence     = phf_pkg::ST_PRESENT;
							nxt.hold_timer   = '0;
							nxt.engage_timer = '0;
							if (fv) nxt.confidence = 1'b1;
							nxt.confirm_cnt  = cur.confirm_cnt + 16'd1;
							ev               = phf_pkg::EV_CONFIRMED;
							flag             = fv;
						end else if (since_sat >= 25'(cfg.left_limit_ms)) begin
							nxt.presence = phf_pkg::ST_AWAY;
							nxt.away_cnt = cur.away_cnt + 16'd1;
							ev           = phf_pkg::EV_AWAY;
						end
					end
					phf_pkg::ST_AWAY: begin
						nxt.since_left_timer = since_sat;
						if (sig) begin
							nxt.presence     = phf_pkg::ST_PRESENT;
							nxt.hold_timer   = '0;
							nxt.engage_timer = '0;
							if (fv) nxt.confidence = 1'b1;
							// long absence counts as a return
							if (since_sat >= 25'(cfg.return_limit_ms)) begin
								nxt.return_cnt = cur.return_cnt + 16'd1;
								ev             = phf_pkg::EV_RETURNED;
							end else begin
								nxt.confirm_cnt = cur.confirm_cnt + 16'd1;
								ev              = phf_pkg::EV_CONFIRMED;
							end
							flag = fv;
						end else if (since_sat >= settle_limit) begin
							nxt.presence = phf_pkg::ST_SETTLED;
							ev           = phf_pkg::EV_SETTLED;
						end
					end
					default: ;
				endcase
			end
			phf_pkg::OP_FACE: begin
				nxt.face_seen = face_ok;
				if (face_ok) nxt.confidence = 1'b1;
			end
			phf_pkg::OP_HEUR_HIGH: nxt.heuristic_seen = 1'b1;
			phf_pkg::OP_HEUR_LOW:  nxt.heuristic_seen = 1'b0;
			phf_pkg::OP_LINK_DOWN: begin
				nxt.face_seen  = 1'b0;
				nxt.confidence = 1'b0;
			end
			default: ;
		endcase
	end

	// transition fields read zero when nothing happened
	always_comb begin
		res.event_kind           = ev;
		res.old_state            = (ev != phf_pkg::EV_NONE) ? phf_pkg::state_code(cur.presence) : '0;
		res.new_state            = (ev != phf_pkg::EV_NONE) ? phf_pkg::state_code(nxt.presence) : '0;
		res.face_flag            = (ev != phf_pkg::EV_NONE) && flag;
		res.current_state        = phf_pkg::state_code(nxt.presence);
		res.face_confidence      = nxt.confidence;
		res.confirmed_total      = nxt.confirm_cnt;
		res.returned_total       = nxt.return_cnt;
		res.away_total           = nxt.away_cnt;
		res.session_time_ms      = nxt.session_timer;
		res.absence_time_ms      = nxt.absence_timer;
	end

endmodule

@@ hdl/presence_hysteresis_fsm.sv @@
// top level of the presence hysteresis block: input register, state, result register
// depends on phf_pkg, phf_item_if, phf_result_if, phf_cfg_regs, phf_step and the macro header
`timescale 1ns / 1ps

// Presence hysteresis machine. Fuses a face box (valid when width and height are
// both nonzero) and a heuristic high/low flag into a seven-state presence machine
// (none, maybe, present, engaged, left recently, away, settled). Sensor requests only
// update the sensor flags and the confidence bit; a tick request advances the
// saturating timers by dt_ms and may make one transition, reported as an event.
// Every request produces exactly one result. Throughput is one request per clock
// unless the output stalls. A request passes the input register, one pass of the
// step logic, which also writes the state registers, and the result register. The
// result register decouples the two sides, so a new request is taken while a result
// waits; only a held result plus a full input register stalls the input. Limits are
// written through write_en / reg_index / write_data; the user must do so only while
// the block is idle, which it does not enforce. Indexes beyond the limits are ignored.

`include "presence_hysteresis_fsm_macros.svh"

module presence_hysteresis_fsm (
	input  logic                              clk,
	input  logic                              arst_n,
	phf_item_if.sink                          item,
	phf_result_if.source                      result,
	input  logic                              write_en,
	input  logic [phf_pkg::REG_IDX_W-1:0]     reg_index,
	input  logic [phf_pkg::LIMIT_W-1:0]       write_data
);

	phf_pkg::cfg_t       cfg;
	phf_pkg::fsm_state_t state_q;
	phf_pkg::fsm_state_t state_next;
	phf_pkg::item_t      item_s1;
	phf_pkg::result_t    step_res;
	phf_pkg::result_t    result_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                advance;

	phf_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.cfg        (cfg)
	);

	// result register empty or being drained
	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op          <= item.op;
			item_s1.dt_ms       <= item.dt_ms;
			item_s1.face_width  <= item.face_width;
			item_s1.face_height <= item.face_height;
		end
	end

	phf_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_next),
		.res  (step_res)
	);

	// machine state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phf_pkg::STATE_RESET;
		end else if (valid_s1 && advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_s2 <= step_res;
		end
	end

	assign result.valid                = valid_s2;
	assign result.event_kind           = result_s2.event_kind;
	assign result.old_state            = result_s2.old_state;
	assign result.new_state            = result_s2.new_state;
	assign result.face_flag            = result_s2.face_flag;
	assign result.current_state        = result_s2.current_state;
	assign result.face_confidence      = result_s2.face_confidence;
	assign result.confirmed_total      = result_s2.confirmed_total;
	assign result.returned_total       = result_s2.returned_total;
	assign result.away_total           = result_s2.away_total;
	assign result.session_time_ms      = result_s2.session_time_ms;
	assign result.absence_time_ms      = result_s2.absence_time_ms;

	// a held result with a full input register freezes the machine
	`PHF_ASSERT_NEXT(a_state_frozen_on_stall, valid_s1 && valid_s2 && !result.ready, $stable(state_q), "state changed while stalled")
	// no request taken while both registers are full and the output is stalled
	`PHF_ASSERT_NOW(a_no_accept_when_full, valid_s1 && valid_s2 && !result.ready, !item.ready, "request accepted while full")
	// a reported transition lands in the reported current state
	`PHF_ASSERT_NOW(a_event_matches_state, result.valid && result.event_kind != phf_pkg::EV_NONE, result.new_state == result.current_state, "event target differs from current state")

endmodule
